@@ src/rbv_pkg.sv @@
// ----------------------------------------------------------------------------
// rbv_pkg
// Shared widths and constants for the realized bipower variation block.
// ----------------------------------------------------------------------------
package rbv_pkg;

  localparam int SUM_W   = 56;   // variance and bipower result width
  localparam int RATIO_W = 18;   // jump ratio width, unsigned Q2.16
  localparam int FRAC_W  = 16;   // fraction bits of the ratio
  localparam int INT_W   = RATIO_W - FRAC_W;
  localparam int WIN_W   = 8;    // window register width
  localparam int BARS_W  = 9;    // saturating bar counter width

  localparam logic [RATIO_W-1:0] RATIO_MAX    = '1;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 8'd100;
  localparam logic [BARS_W-1:0]  BARS_MAX     = '1;
  localparam logic [BARS_W-1:0]  FIRST_RESULT_BAR = 9'd2;

endpackage

@@ src/realized_bipower_variation_core.sv @@
// ----------------------------------------------------------------------------
// realized_bipower_variation_core
// Running realized variance and bipower sums over a bar window, with ratio.
// A request runs through the load, bit-serial multiply, add, subtract and divide
// states; the divider iterations are skipped when the ratio is zero or saturated.
// A new request waits for the previous one to finish, output stall included; the
// bit-serial multipliers and the 18-step divider set how long that takes.
// Reset clears history and sets the window to 100; no ring clearing pass.
// ----------------------------------------------------------------------------
module realized_bipower_variation_core #(
  parameter int RING_DEPTH = 256,
  parameter int PRICE_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rbv_pkg::WIN_W-1:0]   window_length_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [PRICE_BITS-1:0]       close_price_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rbv_pkg::SUM_W-1:0]   realized_variance_o,
  output logic [rbv_pkg::SUM_W-1:0]   bipower_sum_o,
  output logic [rbv_pkg::RATIO_W-1:0] jump_ratio_o
);
  import rbv_pkg::*;

  localparam int PW   = PRICE_BITS;
  localparam int AW   = $clog2(RING_DEPTH);
  localparam int AW1  = AW + 1;
  localparam int RW   = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int AccW = (2 * PW + 9 > SUM_W + 1) ? 2 * PW + 9 : SUM_W + 1;
  localparam logic [RW-1:0] WinMax  = RW'(RING_DEPTH - 2);
  localparam logic [AW-1:0] PtrLast = AW'(RING_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_SUB   = 3'd4;
  localparam logic [2:0] ST_DIVGO = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [WIN_W-1:0]  window_q;
  logic [BARS_W-1:0] bars_q;
  logic [AW-1:0]     ptr_q;
  logic [PW-1:0]     prior_q;
  logic [AccW-1:0]   rv_acc_q, bp_acc_q;
  logic              out_valid_q;
  logic [SUM_W-1:0]  rv_out_q, bp_out_q;
  logic [RATIO_W-1:0] ratio_out_q;

  logic [PW-1:0]     cur_abs_q, prev_abs_q, dep_prev_q;
  logic              dep_v_q, dep_b_q;
  logic              first_q;
  logic [SUM_W-1:0]  rv_res_q, bp_res_q;

  logic [PW:0]       ring_q [RING_DEPTH];
  logic [PW:0]       rd_data_q;

  logic              accept;
  logic [RW-1:0]     win_clamp, reach, n_ext;
  logic [AW1-1:0]    ptr_ext, reach_a, rd_sum;
  logic [AW-1:0]     rd_addr;
  logic [PW:0]       ret;
  logic [PW:0]       ret_neg;
  logic [PW-1:0]     ret_abs;
  logic [PW:0]       rd_neg;
  logic [PW-1:0]     dep_abs, dep_abs_m, dep_prev_m;
  logic [PW-1:0]     dep_sq_op;

  logic              mul_start;
  logic [3:0]        mul_busy;
  logic [2*PW-1:0]   sq_new, sq_dep, bp_new, bp_dep;
  logic              div_start, div_busy;
  logic [RATIO_W-1:0] div_quot;
  logic [SUM_W-1:0]  rv_sat, bp_sat;

  assign accept = in_valid_i && in_ready_o;

  // window reach, clamped so the departing return is still in the ring
  assign win_clamp = (RW'(window_q) > WinMax) ? WinMax : RW'(window_q);
  assign reach     = win_clamp + RW'(1);
  assign n_ext     = RW'(bars_q);

  assign ptr_ext = {1'b0, ptr_q};
  assign reach_a = reach[AW1-1:0];
  assign rd_sum  = (ptr_ext >= reach_a) ? ptr_ext - reach_a
                                        : ptr_ext + AW1'(RING_DEPTH) - reach_a;
  assign rd_addr = rd_sum[AW-1:0];

  assign ret     = {1'b0, close_price_i} - {1'b0, prior_q};
  assign ret_neg = ~ret + (PW+1)'(1);
  assign ret_abs = ret[PW] ? ret_neg[PW-1:0] : ret[PW-1:0];

  assign rd_neg     = ~rd_data_q + (PW+1)'(1);
  assign dep_abs    = rd_data_q[PW] ? rd_neg[PW-1:0] : rd_data_q[PW-1:0];
  assign dep_abs_m  = dep_v_q ? dep_abs : '0;
  assign dep_prev_m = dep_b_q ? dep_prev_q : '0;

  // first result also folds in the first return, unless it already left the window
  assign dep_sq_op = first_q ? (dep_v_q ? '0 : prev_abs_q) : dep_abs_m;

  assign rv_sat = (|rv_acc_q[AccW-1:SUM_W]) ? '1 : rv_acc_q[SUM_W-1:0];
  assign bp_sat = (|bp_acc_q[AccW-1:SUM_W]) ? '1 : bp_acc_q[SUM_W-1:0];

  assign mul_start = (state_q == ST_LOAD);
  assign div_start = (state_q == ST_DIVGO);

  // ring of returns
  always_ff @(posedge clk_i) begin
    if (accept && (bars_q != '0)) begin
      ring_q[ptr_q] <= ret;
    end
    if (accept) begin
      rd_data_q <= ring_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (bars_q >= FIRST_RESULT_BAR)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = ST_MUL;
      ST_MUL: begin
        if (mul_busy == '0) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD:   state_d = ST_SUB;
      ST_SUB:   state_d = ST_DIVGO;
      ST_DIVGO: state_d = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= WINDOW_RESET;
      bars_q      <= '0;
      ptr_q       <= '0;
      prior_q     <= '0;
      rv_acc_q    <= '0;
      bp_acc_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // window write restarts history
        window_q <= window_length_i;
        bars_q   <= '0;
        ptr_q    <= '0;
        prior_q  <= '0;
        rv_acc_q <= '0;
        bp_acc_q <= '0;
      end else begin
        if (accept) begin
          prior_q <= close_price_i;
          if (bars_q != BARS_MAX) begin
            bars_q <= bars_q + BARS_W'(1);
          end
          if (bars_q != '0) begin
            ptr_q <= (ptr_q == PtrLast) ? '0 : ptr_q + AW'(1);
          end
        end
        if (state_q == ST_ADD) begin
          rv_acc_q <= rv_acc_q + AccW'(sq_new);
          bp_acc_q <= bp_acc_q + AccW'(bp_new);
        end
        if (state_q == ST_SUB) begin
          if (first_q) begin
            rv_acc_q <= rv_acc_q + AccW'(sq_dep);
          end else begin
            rv_acc_q <= rv_acc_q - AccW'(sq_dep);
          end
          bp_acc_q <= bp_acc_q - AccW'(bp_dep);
        end
      end
      if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (bars_q != '0)) begin
      cur_abs_q  <= ret_abs;
      prev_abs_q <= cur_abs_q;
      dep_v_q    <= n_ext > reach;
      dep_b_q    <= n_ext > reach + RW'(1);
      first_q    <= (bars_q == FIRST_RESULT_BAR);
    end
    if (state_q == ST_LOAD) begin
      dep_prev_q <= dep_abs;
    end
    if (state_q == ST_DIVGO) begin
      rv_res_q <= rv_sat;
      bp_res_q <= bp_sat;
    end
    if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      rv_out_q    <= rv_res_q;
      bp_out_q    <= bp_res_q;
      ratio_out_q <= div_quot;
    end
  end

  rbv_serial_mul #(.WIDTH(PW)) u_mul_sq_new (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (cur_abs_q),
    .b_i     (cur_abs_q),
    .busy_o  (mul_busy[0]),
    .prod_o  (sq_new)
  );

  rbv_serial_mul #(.WIDTH(PW)) u_mul_sq_dep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (dep_sq_op),
    .b_i     (dep_sq_op),
    .busy_o  (mul_busy[1]),
    .prod_o  (sq_dep)
  );

  rbv_serial_mul #(.WIDTH(PW)) u_mul_bp_new (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (cur_abs_q),
    .b_i     (prev_abs_q),
    .busy_o  (mul_busy[2]),
    .prod_o  (bp_new)
  );

  rbv_serial_mul #(.WIDTH(PW)) u_mul_bp_dep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (dep_abs_m),
    .b_i     (dep_prev_m),
    .busy_o  (mul_busy[3]),
    .prod_o  (bp_dep)
  );

  rbv_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (bp_sat),
    .den_i   (rv_sat),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  assign in_ready_o          = (state_q == ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign realized_variance_o = rv_out_q;
  assign bipower_sum_o       = bp_out_q;
  assign jump_ratio_o        = ratio_out_q;

endmodule

@@ src/rbv_serial_mul.sv @@
// ----------------------------------------------------------------------------
// rbv_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rbv_serial_mul #(
  parameter int WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic               busy_o,
  output logic [2*WIDTH-1:0] prod_o
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic               busy_q, busy_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0]   mcand_q, mcand_d;
  logic [2*WIDTH-1:0] prod_q, prod_d;
  logic [WIDTH:0]     upper;

  // upper half accumulates, product shifts right one bit per step
  assign upper = {1'b0, prod_q[2*WIDTH-1:WIDTH]}
               + (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    mcand_d = mcand_q;
    prod_d  = prod_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CntW'(WIDTH);
      mcand_d = a_i;
      prod_d  = {{WIDTH{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_d = {upper, prod_q[WIDTH-1:1]};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
  end

  assign busy_o = busy_q;
  assign prod_o = prod_q;

endmodule

@@ src/rbv_serial_div.sv @@
// ----------------------------------------------------------------------------
// rbv_serial_div
// Radix-2 restoring divider for the Q2.16 ratio, saturating at 4.0.
// ----------------------------------------------------------------------------
module rbv_serial_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rbv_pkg::SUM_W-1:0]    num_i,
  input  logic [rbv_pkg::SUM_W-1:0]    den_i,
  output logic                         busy_o,
  output logic [rbv_pkg::RATIO_W-1:0]  quot_o
);
  import rbv_pkg::*;

  localparam int CntW = $clog2(RATIO_W + 1);

  logic               busy_q, busy_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   den_q, den_d;
  logic [INT_W-1:0]   feed_q, feed_d;
  logic [RATIO_W-1:0] quot_q, quot_d;
  logic [SUM_W:0]     trial;
  logic [SUM_W:0]     diff;
  logic               ge;
  logic               sat;

  assign trial = {rem_q, feed_q[INT_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};
  // quotient of 4.0 or more cannot fit two integer bits
  assign sat   = {{INT_W{1'b0}}, num_i} >= {den_i, {INT_W{1'b0}}};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    feed_d = feed_q;
    quot_d = quot_q;
    if (start_i) begin
      if (den_i == '0) begin
        quot_d = '0;
      end else if (sat) begin
        quot_d = RATIO_MAX;
      end else begin
        // partial remainder after the all-zero quotient bits above Q2.16
        rem_d  = num_i >> INT_W;
        feed_d = num_i[INT_W-1:0];
        den_d  = den_i;
        quot_d = '0;
        cnt_d  = CntW'(RATIO_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      quot_d = {quot_q[RATIO_W-2:0], ge};
      feed_d = feed_q << 1;
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    feed_q <= feed_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

@@ verif/realized_bipower_variation_core_test.sv @@
// ----------------------------------------------------------------------------
// realized_bipower_variation_core_test
// Self-checking bench for the realized variance / bipower block. A scripted
// opening covers zero variance, full-swing returns, ratio saturation at and
// above 4.0 and window clamping. Random price walks follow under several
// window settings, with random idling on both sides. Every result is checked,
// against scripted values in the opening and otherwise against an in-bench model of the ring and the window sums.
// ----------------------------------------------------------------------------
module realized_bipower_variation_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbv_pkg::*;

  localparam int PRICE_W       = 24;
  localparam int PRICE_CEIL    = 2**PRICE_W - 1;
  localparam int HIST_DEPTH    = 256;
  localparam int MAX_REACH     = HIST_DEPTH - 2;
  localparam int NUM_W         = SUM_W + FRAC_W;
  localparam int MAX_IDLE      = 11;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 4000;
  localparam int BAR_TARGET    = 1320;

  localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
  localparam logic [SUM_W-1:0]   FULL_SQ   = 56'hFFFF_FE00_0001;  // (2^24-1)^2

  typedef struct packed {
    logic [SUM_W-1:0]   variance;
    logic [SUM_W-1:0]   bipower;
    logic [RATIO_W-1:0] ratio;
  } bar_stats_t;

  typedef enum logic [1:0] {ROW_BAR, ROW_BAR_KNOWN, ROW_WINDOW} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PRICE_W-1:0] value;
    bar_stats_t         stats;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [WIN_W-1:0]     window_length_i = WINDOW_RESET;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PRICE_W-1:0]   close_price_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SUM_W-1:0]     realized_variance_o;
  logic [SUM_W-1:0]     bipower_sum_o;
  logic [RATIO_W-1:0]   jump_ratio_o;

  always #4 clk_i = ~clk_i;

  realized_bipower_variation_core #(
    .RING_DEPTH(HIST_DEPTH),
    .PRICE_BITS(PRICE_W)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .window_length_i    (window_length_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .close_price_i      (close_price_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .realized_variance_o(realized_variance_o),
    .bipower_sum_o      (bipower_sum_o),
    .jump_ratio_o       (jump_ratio_o)
  );

  // model of the block state
  logic signed [PRICE_W:0] ret_hist [HIST_DEPTH];
  logic [PRICE_W-1:0]      last_close;
  logic [BARS_W-1:0]       bar_count;
  logic [7:0]              hist_wr;
  logic [WIN_W-1:0]        win_reg;

  bar_stats_t  owed_stats [$];
  script_row_t opening_rows [$];

  bit          steady = 1'b0;
  int unsigned bars_sent = 0;
  int unsigned results_checked = 0;
  int unsigned windows_set = 0;
  int unsigned faults = 0;
  int unsigned quiet_cycles = 0;

  function automatic void clear_history();
    foreach (ret_hist[i]) ret_hist[i] = '0;
    last_close = '0;
    bar_count  = '0;
    hist_wr    = '0;
  endfunction

  // magnitude of the return that lies `back` places behind the newest
  function automatic logic [SUM_W-1:0] ret_mag(input int unsigned back);
    logic [7:0]         idx;
    logic [PRICE_W:0]   m;
    idx = hist_wr - 8'd1 - back[7:0];
    m = ret_hist[idx][PRICE_W] ? -ret_hist[idx] : ret_hist[idx];
    return SUM_W'(m);
  endfunction

  function automatic logic [RATIO_W-1:0] q2_16_ratio(input logic [SUM_W-1:0] bp,
                                                     input logic [SUM_W-1:0] rv);
    logic [NUM_W-1:0] quot;
    if (rv == '0) return '0;
    if ((bp >> 2) >= rv) return RATIO_MAX;
    quot = {bp, {FRAC_W{1'b0}}} / NUM_W'(rv);
    return quot[RATIO_W-1:0];
  endfunction

  // takes one closing price, returns 1 when the bar yields statistics
  function automatic bit advance_bar(input logic [PRICE_W-1:0] price,
                                     output bar_stats_t s);
    int unsigned n, reach, cnt_v, cnt_b, k;
    logic [SUM_W-1:0] rv, bp;
    n = 32'(bar_count);
    s = '0;
    if (bar_count != BARS_MAX) bar_count = bar_count + 1'b1;
    if (n == 0) begin
      last_close = price;
      return 1'b0;
    end
    ret_hist[hist_wr] = $signed({1'b0, price}) - $signed({1'b0, last_close});
    hist_wr = hist_wr + 8'd1;
    last_close = price;
    if (n < FIRST_RESULT_BAR) return 1'b0;
    reach = ((win_reg > MAX_REACH) ? MAX_REACH : win_reg) + 1;
    cnt_v = (n < reach) ? n : reach;
    cnt_b = (n - 1 < reach) ? n - 1 : reach;
    // at 24-bit prices the sums stay below 2^56, no saturation needed
    rv = '0;
    bp = '0;
    for (k = 0; k < cnt_v; k++) rv += ret_mag(k) * ret_mag(k);
    for (k = 0; k < cnt_b; k++) bp += ret_mag(k) * ret_mag(k + 1);
    s.variance = rv;
    s.bipower  = bp;
    s.ratio    = q2_16_ratio(bp, rv);
    return 1'b1;
  endfunction

  function automatic logic [PRICE_W-1:0] next_close(input logic [PRICE_W-1:0] prev);
    int step;
    int moved;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: step = $urandom_range(0, 128);
      4:          return prev;
      5:          return $urandom_range(0, 1) ? PRICE_TOP : '0;
      6, 7:       return PRICE_W'($urandom());
      default:    step = $urandom_range(0, 4096);
    endcase
    if ($urandom_range(0, 1) == 1) step = -step;
    moved = int'(prev) + step;
    if (moved < 0) moved = 0;
    else if (moved > PRICE_CEIL) moved = PRICE_CEIL;
    return moved[PRICE_W-1:0];
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [PRICE_W-1:0] value,
                         input logic [SUM_W-1:0] rv, input logic [SUM_W-1:0] bp,
                         input logic [RATIO_W-1:0] q);
    script_row_t row;
    row.kind           = kind;
    row.value          = value;
    row.stats.variance = rv;
    row.stats.bipower  = bp;
    row.stats.ratio    = q;
    opening_rows.push_back(row);
  endtask

  // one request; valid stays up afterwards in case the next one follows at once
  task automatic send_bar(input logic [PRICE_W-1:0] price, input bit known,
                          input bar_stats_t known_stats);
    int unsigned gap;
    bar_stats_t  s;
    gap = steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    close_price_i <= price;
    do @(posedge clk_i); while (!in_ready_o);
    bars_sent++;
    if (advance_bar(price, s)) owed_stats.push_back(known ? known_stats : s);
  endtask

  // bars 0 and 1 give no result, so let the block settle after the last one
  task automatic set_window(input logic [WIN_W-1:0] w);
    in_valid_i <= 1'b0;
    while (owed_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i        <= 1'b1;
    window_length_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = w;
    clear_history();
    windows_set++;
  endtask

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        // sometimes hold off only once the result is already waiting
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk_i); while (!out_valid_o);
        end
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_result
    bar_stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_stats.size() == 0) begin
        $display("%0t: unexpected result variance %0h bipower %0h ratio %0h", $time,
                 realized_variance_o, bipower_sum_o, jump_ratio_o);
        faults++;
      end else begin
        want = owed_stats.pop_front();
        results_checked++;
        if (realized_variance_o !== want.variance) begin
          $display("%0t: realized_variance expected %0h got %0h", $time,
                   want.variance, realized_variance_o);
          faults++;
        end
        if (bipower_sum_o !== want.bipower) begin
          $display("%0t: bipower_sum expected %0h got %0h", $time,
                   want.bipower, bipower_sum_o);
          faults++;
        end
        if (jump_ratio_o !== want.ratio) begin
          $display("%0t: jump_ratio expected %0h got %0h", $time,
                   want.ratio, jump_ratio_o);
          faults++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles, %0d results still owed", $time,
                 STALL_LIMIT, owed_stats.size());
        $display("realized_bipower_variation_core regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [PRICE_W-1:0] price;
    logic [WIN_W-1:0]   w;
    int unsigned        len;
    clear_history();
    win_reg = WINDOW_RESET;

    // reset window of 100: zero variance, full-swing returns up and down
    add_row(ROW_BAR,       '0,        '0,          '0,      '0);
    add_row(ROW_BAR,       '0,        '0,          '0,      '0);
    add_row(ROW_BAR_KNOWN, '0,        '0,          '0,      '0);
    add_row(ROW_BAR_KNOWN, PRICE_TOP, FULL_SQ,     '0,      '0);
    add_row(ROW_BAR_KNOWN, '0,        FULL_SQ * 2, FULL_SQ, 18'h08000);
    add_row(ROW_BAR,       PRICE_TOP, '0,          '0,      '0);
    add_row(ROW_BAR,       '0,        '0,          '0,      '0);
    // window 0: old return outside the variance term drives the ratio past 4.0
    add_row(ROW_WINDOW,    '0,        '0,          '0,      '0);
    add_row(ROW_BAR,       24'd1000,  '0,          '0,      '0);
    add_row(ROW_BAR,       24'd1100,  '0,          '0,      '0);
    add_row(ROW_BAR_KNOWN, 24'd1101,  56'd1,       56'd100, RATIO_MAX);
    add_row(ROW_BAR_KNOWN, 24'd1105,  56'd16,      56'd4,   18'h04000);
    add_row(ROW_BAR_KNOWN, 24'd1106,  56'd1,       56'd4,   RATIO_MAX);
    add_row(ROW_BAR_KNOWN, 24'd1106,  '0,          '0,      '0);
    add_row(ROW_BAR_KNOWN, 24'd1109,  56'd9,       '0,      '0);
    add_row(ROW_BAR,       24'd1100,  '0,          '0,      '0);
    // all-ones window clamps to the widest reach
    add_row(ROW_WINDOW,    24'd255,   '0,          '0,      '0);
    add_row(ROW_BAR,       24'd5,     '0,          '0,      '0);
    add_row(ROW_BAR,       '0,        '0,          '0,      '0);
    add_row(ROW_BAR,       24'd7,     '0,          '0,      '0);
    add_row(ROW_BAR,       PRICE_TOP, '0,          '0,      '0);
    add_row(ROW_BAR,       '0,        '0,          '0,      '0);
    add_row(ROW_WINDOW,    PRICE_W'(WINDOW_RESET), '0, '0,  '0);
    add_row(ROW_BAR,       24'd12345, '0,          '0,      '0);
    add_row(ROW_BAR,       24'd12340, '0,          '0,      '0);
    add_row(ROW_BAR,       24'd12346, '0,          '0,      '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      if (opening_rows[i].kind == ROW_WINDOW) begin
        set_window(opening_rows[i].value[WIN_W-1:0]);
      end else begin
        send_bar(opening_rows[i].value, opening_rows[i].kind == ROW_BAR_KNOWN,
                 opening_rows[i].stats);
      end
    end

    // long run at the widest window: ring wraps and the bar counter saturates
    set_window(WIN_W'(MAX_REACH));
    price = PRICE_W'($urandom());
    repeat (600) begin
      price = next_close(price);
      send_bar(price, 1'b0, '0);
    end

    while (bars_sent < BAR_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: w = WIN_W'($urandom_range(0, 3));
        3, 4:    w = $urandom_range(0, 1) ? 8'd255 : 8'(MAX_REACH);
        default: w = WIN_W'($urandom_range(0, 255));
      endcase
      set_window(w);
      steady = ($urandom_range(0, 3) == 0);
      len = $urandom_range(3, 90);
      price = PRICE_W'($urandom());
      repeat (len) begin
        price = next_close(price);
        send_bar(price, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (owed_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d closing prices over %0d window writes, %0d results checked, %0d mismatches",
             bars_sent, windows_set, results_checked, faults);
    if (faults == 0) begin
      $display("realized_bipower_variation_core regression: pass");
    end else begin
      $display("realized_bipower_variation_core regression: fail");
    end
    $finish;
  end

endmodule
